### rtl/bat_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the burst assembly timer/size controller
// no dependencies

package bat_pkg;

  localparam int DESTINATIONS_DEF = 16;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic CAUSE_SIZE    = 1'b0;
  localparam logic CAUSE_TIMEOUT = 1'b1;

  localparam logic REG_TIMEOUT   = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [23:0] TIMEOUT_RESET   = 24'd1000;
  localparam logic [31:0] THRESHOLD_RESET = 32'd10000;

  localparam logic [31:0] BYTES_MAX   = 32'hFFFF_FFFF;
  localparam logic [15:0] PACKETS_MAX = 16'hFFFF;

  // one stored burst entry
  typedef struct packed {
    logic [31:0] bytes;
    logic [15:0] packets;
    logic [23:0] ticks;
  } entry_t;

  typedef struct packed {
    logic [23:0] timeout_ticks;
    logic [31:0] size_threshold;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  dest;
    logic [31:0] bytes;
    logic [15:0] packets;
    logic        cause;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_TICK_END
  } state_t;

endpackage

### rtl/bat_ram.sv
`timescale 1ns / 1ps
// single-port-write, single-port-read synchronous ram, registered read data
// no dependencies

module bat_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 72,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/bat_ctrl.sv
`timescale 1ns / 1ps
// sequencer for arrivals and tick sweeps: read-modify-write of the entry ram,
// open flags, pending release and output register; uses bat_pkg

module bat_ctrl #(
  parameter int DESTINATIONS = bat_pkg::DESTINATIONS_DEF,
  parameter int IW           = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  bat_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [3:0]       destination,
  input  logic [15:0]      byte_length,
  output logic             out_valid,
  input  logic             out_stall,
  output bat_pkg::result_t out_res,
  output logic             wr_en,
  output logic [IW-1:0]    wr_addr,
  output bat_pkg::entry_t  wr_data,
  output logic             rd_en,
  output logic [IW-1:0]    rd_addr,
  input  bat_pkg::entry_t  rd_data
);

  bat_pkg::state_t state, state_next;

  logic [DESTINATIONS-1:0] open_q;
  logic [IW-1:0]           d_reg;
  logic [15:0]             len_reg;
  logic [IW-1:0]           ptr;
  bat_pkg::result_t        pend;
  logic                    pend_valid;

  logic            in_fire;
  logic            dest_ok;
  logic [IW-1:0]   dest_idx;
  logic            out_free;
  logic            out_fire;
  logic            ptr_end;

  bat_pkg::entry_t base;
  logic [32:0]     sum;
  logic [31:0]     new_bytes;
  logic [15:0]     new_pkts;
  logic            arr_rel;
  logic            expire;

  logic            load_out;
  bat_pkg::result_t out_next;
  logic            take_pend;
  logic            clear_pend;
  logic            advance;
  logic            set_open;
  logic            clr_open;
  logic [IW-1:0]   open_idx;

  assign in_fire  = in_valid && !in_stall;
  assign dest_ok  = (32'(destination) < 32'(DESTINATIONS));
  assign dest_idx = IW'(destination);
  assign out_fire = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign ptr_end  = (ptr == IW'(DESTINATIONS - 1));

  // arrival update and tick expiry test
  always_comb begin
    if (open_q[d_reg]) begin
      base = rd_data;
    end else begin
      base = '{bytes: 32'd0, packets: 16'd0, ticks: cfg.timeout_ticks};
    end
    sum       = {1'b0, base.bytes} + {17'd0, len_reg};
    new_bytes = sum[32] ? bat_pkg::BYTES_MAX : sum[31:0];
    new_pkts  = (base.packets == bat_pkg::PACKETS_MAX) ? base.packets
                                                       : base.packets + 16'd1;
    arr_rel   = (new_bytes >= cfg.size_threshold);
    expire    = (rd_data.ticks <= 24'd1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bat_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (operation == bat_pkg::OP_TICK) begin
            state_next = bat_pkg::ST_TICK_RD;
          end else if (dest_ok) begin
            state_next = bat_pkg::ST_ARR;
          end
        end
      end
      bat_pkg::ST_ARR: begin
        if (!arr_rel || out_free) begin
          state_next = bat_pkg::ST_IDLE;
        end
      end
      bat_pkg::ST_TICK_RD: begin
        if (open_q[ptr]) begin
          state_next = bat_pkg::ST_TICK_EV;
        end else if (ptr_end) begin
          state_next = bat_pkg::ST_TICK_END;
        end
      end
      bat_pkg::ST_TICK_EV: begin
        if (!expire || !pend_valid || out_free) begin
          state_next = ptr_end ? bat_pkg::ST_TICK_END : bat_pkg::ST_TICK_RD;
        end
      end
      bat_pkg::ST_TICK_END: begin
        if (!pend_valid || out_free) begin
          state_next = bat_pkg::ST_IDLE;
        end
      end
      default: state_next = bat_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = (state != bat_pkg::ST_IDLE);
    rd_en      = 1'b0;
    rd_addr    = ptr;
    wr_en      = 1'b0;
    wr_addr    = d_reg;
    wr_data    = rd_data;
    load_out   = 1'b0;
    out_next   = pend;
    take_pend  = 1'b0;
    clear_pend = 1'b0;
    advance    = 1'b0;
    set_open   = 1'b0;
    clr_open   = 1'b0;
    open_idx   = d_reg;
    case (state)
      bat_pkg::ST_IDLE: begin
        rd_en   = in_fire && (operation == bat_pkg::OP_ARRIVAL) && dest_ok;
        rd_addr = dest_idx;
      end
      bat_pkg::ST_ARR: begin
        wr_data = '{bytes: new_bytes, packets: new_pkts, ticks: base.ticks};
        if (!arr_rel) begin
          wr_en    = 1'b1;
          set_open = 1'b1;
        end else if (out_free) begin
          load_out = 1'b1;
          clr_open = 1'b1;
          out_next = '{dest: 4'(d_reg), bytes: new_bytes, packets: new_pkts,
                       cause: bat_pkg::CAUSE_SIZE, last: 1'b1};
        end
      end
      bat_pkg::ST_TICK_RD: begin
        rd_en   = open_q[ptr];
        advance = !open_q[ptr] && !ptr_end;
      end
      bat_pkg::ST_TICK_EV: begin
        wr_addr  = ptr;
        open_idx = ptr;
        wr_data  = '{bytes: rd_data.bytes, packets: rd_data.packets,
                     ticks: rd_data.ticks - 24'd1};
        if (!expire) begin
          wr_en   = 1'b1;
          advance = !ptr_end;
        end else if (!pend_valid || out_free) begin
          take_pend = 1'b1;
          clr_open  = 1'b1;
          load_out  = pend_valid;
          out_next  = '{dest: pend.dest, bytes: pend.bytes, packets: pend.packets,
                        cause: pend.cause, last: 1'b0};
          advance   = !ptr_end;
        end
      end
      bat_pkg::ST_TICK_END: begin
        if (pend_valid && out_free) begin
          load_out   = 1'b1;
          clear_pend = 1'b1;
          out_next   = '{dest: pend.dest, bytes: pend.bytes, packets: pend.packets,
                         cause: pend.cause, last: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bat_pkg::ST_IDLE;
      open_q     <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      ptr        <= '0;
    end else begin
      state <= state_next;
      if (set_open) begin
        open_q[open_idx] <= 1'b1;
      end else if (clr_open) begin
        open_q[open_idx] <= 1'b0;
      end
      if (take_pend) begin
        pend_valid <= 1'b1;
      end else if (clear_pend) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        ptr <= '0;
      end else if (advance) begin
        ptr <= ptr + IW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      d_reg   <= dest_idx;
      len_reg <= byte_length;
    end
    if (take_pend) begin
      pend <= '{dest: 4'(ptr), bytes: rd_data.bytes, packets: rd_data.packets,
                cause: bat_pkg::CAUSE_TIMEOUT, last: 1'b0};
    end
    if (load_out) begin
      out_res <= out_next;
    end
  end

endmodule

### rtl/burst_assembly_timer_size.sv
`timescale 1ns / 1ps
// top level of the burst assembly controller: configuration registers,
// entry ram and sequencer; uses bat_pkg, bat_ram, bat_ctrl

// Per-destination burst assembly with a hybrid timeout / size release rule.
// Burst totals and timers live in one synchronous ram, one entry per
// destination; open flags are flip-flops cleared by reset. An arrival is a
// ram read of its entry, then an update that is written back or released. A
// tick is accepted, then sweeps all destinations: a closed destination is
// skipped in ST_TICK_RD, an open one is read there and then updated or
// released in ST_TICK_EV, and ST_TICK_END closes the sweep. Releases found
// during a sweep go out in ascending destination order; the last release of
// an item is held until the sweep ends so it can carry last_release. A
// stalled output holds the sweep at the next release.

module burst_assembly_timer_size #(
  parameter int DESTINATIONS = bat_pkg::DESTINATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [3:0]  destination,
  input  logic [15:0] byte_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  burst_destination,
  output logic [31:0] burst_bytes,
  output logic [15:0] burst_packets,
  output logic        release_cause,
  output logic        last_release
);

  localparam int IW = (DESTINATIONS > 1) ? $clog2(DESTINATIONS) : 1;
  localparam int EW = $bits(bat_pkg::entry_t);

  bat_pkg::cfg_t    cfg;
  bat_pkg::result_t res;
  bat_pkg::entry_t  wr_data;
  bat_pkg::entry_t  rd_data;
  logic             wr_en;
  logic             rd_en;
  logic [IW-1:0]    wr_addr;
  logic [IW-1:0]    rd_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks  <= bat_pkg::TIMEOUT_RESET;
      cfg.size_threshold <= bat_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bat_pkg::REG_TIMEOUT:   cfg.timeout_ticks  <= cfg_data[23:0];
        bat_pkg::REG_THRESHOLD: cfg.size_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bat_ram #(
    .DEPTH (DESTINATIONS),
    .WIDTH (EW),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bat_ctrl #(
    .DESTINATIONS (DESTINATIONS),
    .IW           (IW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .destination (destination),
    .byte_length (byte_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  assign burst_destination = res.dest;
  assign burst_bytes       = res.bytes;
  assign burst_packets     = res.packets;
  assign release_cause     = res.cause;
  assign last_release      = res.last;

endmodule

### tb/burst_assembly_timer_size_test.sv
`timescale 1ns / 1ps
// self-checking bench for burst_assembly_timer_size: directed rows, then random traffic
// under four idling phases, checked against a per-destination burst predictor
// depends on bat_pkg and the burst_assembly_timer_size rtl

module burst_assembly_timer_size_test;

  localparam int      CLK_HALF        = 6;
  localparam int      RESET_CYCLES    = 9;
  localparam int      SETTLE_CYCLES   = 40;
  localparam int      LONG_HOLD       = 300;
  localparam int      ITEMS_PER_PHASE = 108;
  localparam int      REPORT_LIMIT    = 10;
  localparam longint  WATCHDOG_NS     = 12_000_000;

  typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [3:0]        dest;
    logic [15:0]       len;
    int                reps;
    logic              idx;
    logic [31:0]       value;
    bit                typed;
    bat_pkg::result_t  want;
  } stim_row_t;

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready;
  logic        cfg_index   = bat_pkg::REG_TIMEOUT;
  logic [31:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic        operation   = bat_pkg::OP_ARRIVAL;
  logic [3:0]  destination = '0;
  logic [15:0] byte_length = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [3:0]  burst_destination;
  logic [31:0] burst_bytes;
  logic [15:0] burst_packets;
  logic        release_cause;
  logic        last_release;

  // predictor state
  bit          burst_live  [bat_pkg::DESTINATIONS_DEF];
  bit [31:0]   acc_bytes   [bat_pkg::DESTINATIONS_DEF];
  bit [15:0]   acc_packets [bat_pkg::DESTINATIONS_DEF];
  bit [23:0]   timer_left  [bat_pkg::DESTINATIONS_DEF];
  bit [23:0]   timeout_cfg   = bat_pkg::TIMEOUT_RESET;
  bit [31:0]   threshold_cfg = bat_pkg::THRESHOLD_RESET;

  bat_pkg::result_t pending_releases [$];
  stim_row_t        stim_rows [$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_requests  = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int ticks_sent     = 0;
  int releases_seen  = 0;

  burst_assembly_timer_size dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .operation         (operation),
    .destination       (destination),
    .byte_length       (byte_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .burst_destination (burst_destination),
    .burst_bytes       (burst_bytes),
    .burst_packets     (burst_packets),
    .release_cause     (release_cause),
    .last_release      (last_release)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #WATCHDOG_NS;
    $display("timeout with %0d releases outstanding", pending_releases.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic void push_release(input logic [3:0] d, input logic cause);
    bat_pkg::result_t r;
    r.dest    = d;
    r.bytes   = acc_bytes[d];
    r.packets = acc_packets[d];
    r.cause   = cause;
    r.last    = 1'b0;
    pending_releases.push_back(r);
    burst_live[d] = 1'b0;
  endfunction

  function automatic int predict_releases(input logic op, input logic [3:0] d,
                                          input logic [15:0] len);
    int        n;
    bit [32:0] sum;
    n = 0;
    if (op == bat_pkg::OP_ARRIVAL) begin
      if (!burst_live[d]) begin
        burst_live[d]  = 1'b1;
        acc_bytes[d]   = '0;
        acc_packets[d] = '0;
        timer_left[d]  = timeout_cfg;
      end
      sum = {1'b0, acc_bytes[d]} + {17'd0, len};
      acc_bytes[d] = (sum > {1'b0, bat_pkg::BYTES_MAX}) ? bat_pkg::BYTES_MAX : sum[31:0];
      if (acc_packets[d] != bat_pkg::PACKETS_MAX) acc_packets[d]++;
      if (acc_bytes[d] >= threshold_cfg) begin
        push_release(d, bat_pkg::CAUSE_SIZE);
        n = 1;
      end
    end else begin
      for (int k = 0; k < bat_pkg::DESTINATIONS_DEF; k++) begin
        if (burst_live[k]) begin
          if (timer_left[k] <= 24'd1) begin
            timer_left[k] = '0;
            push_release(k[3:0], bat_pkg::CAUSE_TIMEOUT);
            n++;
          end else begin
            timer_left[k]--;
          end
        end
      end
    end
    if (n > 0) pending_releases[pending_releases.size() - 1].last = 1'b1;
    return n;
  endfunction

  function automatic void add_item(input logic op, input logic [3:0] d,
                                   input logic [15:0] len, input int reps);
    stim_row_t r;
    r = '{kind: ROW_ITEM, op: op, dest: d, len: len, reps: reps,
          idx: bat_pkg::REG_TIMEOUT, value: '0, typed: 1'b0, want: '0};
    stim_rows.push_back(r);
  endfunction

  function automatic void add_typed(input logic op, input logic [3:0] d,
                                    input logic [15:0] len, input logic [3:0] wdest,
                                    input logic [31:0] wbytes, input logic [15:0] wpkts,
                                    input logic wcause);
    stim_row_t r;
    r = '{kind: ROW_ITEM, op: op, dest: d, len: len, reps: 1,
          idx: bat_pkg::REG_TIMEOUT, value: '0, typed: 1'b1, want: '0};
    r.want = '{dest: wdest, bytes: wbytes, packets: wpkts, cause: wcause, last: 1'b1};
    stim_rows.push_back(r);
  endfunction

  function automatic void add_reg(input logic idx, input logic [31:0] value);
    stim_row_t r;
    r = '{kind: ROW_REG, op: bat_pkg::OP_ARRIVAL, dest: '0, len: '0, reps: 0, idx: idx,
          value: value, typed: 1'b0, want: '0};
    stim_rows.push_back(r);
  endfunction

  task automatic send_item(input logic op, input logic [3:0] d, input logic [15:0] len,
                           input bit typed, input bat_pkg::result_t want);
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    destination <= d;
    byte_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == bat_pkg::OP_TICK) ticks_sent++;
    n = predict_releases(op, d, len);
    if (typed) begin
      repeat (n) void'(pending_releases.pop_back());
      pending_releases.push_back(want);
    end
  endtask

  // wait until every release is out and any sweep has finished
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_releases.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == bat_pkg::REG_TIMEOUT) timeout_cfg = value[23:0];
    else threshold_cfg = value;
  endtask

  initial begin : release_sink
    bat_pkg::result_t got;
    bat_pkg::result_t want;
    int               hold_left;
    int               holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{dest: burst_destination, bytes: burst_bytes, packets: burst_packets,
                cause: release_cause, last: last_release};
        releases_seen++;
        if (pending_releases.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("unexpected release: dest %0d bytes %0d packets %0d cause %0d last %0d",
                     got.dest, got.bytes, got.packets, got.cause, got.last);
        end else begin
          want = pending_releases.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("release mismatch: expected dest %0d bytes %0d packets %0d",
                       want.dest, want.bytes, want.packets);
              $display("  expected cause %0d last %0d", want.cause, want.last);
              $display("  got dest %0d bytes %0d packets %0d cause %0d last %0d",
                       got.dest, got.bytes, got.packets, got.cause, got.last);
            end
          end
        end
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    int          phase_items;
    int          pick;
    int          send_idle_by_phase [4];
    int          stall_by_phase [4];
    bit [31:0]   timeout_pick;
    bit [31:0]   threshold_pick;
    logic [15:0] len_pick;

    send_idle_by_phase = '{0, 74, 0, 34};
    stall_by_phase     = '{0, 0, 74, 34};
    for (int k = 0; k < bat_pkg::DESTINATIONS_DEF; k++) begin
      burst_live[k]  = 1'b0;
      acc_bytes[k]   = '0;
      acc_packets[k] = '0;
      timer_left[k]  = '0;
    end

    // reset values of the registers
    add_item(bat_pkg::OP_TICK, 4'hF, 16'hFFFF, 1);
    add_item(bat_pkg::OP_ARRIVAL, 4'h0, 16'h0000, 1);
    add_item(bat_pkg::OP_ARRIVAL, 4'hF, 16'd9999, 1);
    add_typed(bat_pkg::OP_ARRIVAL, 4'hF, 16'd1, 4'hF, 32'd10000, 16'd2,
              bat_pkg::CAUSE_SIZE);
    add_typed(bat_pkg::OP_ARRIVAL, 4'h3, 16'hFFFF, 4'h3, 32'd65535, 16'd1,
              bat_pkg::CAUSE_SIZE);
    add_item(bat_pkg::OP_TICK, 4'h0, 16'h0000, 1);
    // shortest timer, largest threshold
    add_reg(bat_pkg::REG_TIMEOUT, 32'd1);
    add_reg(bat_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
    add_item(bat_pkg::OP_ARRIVAL, 4'h7, 16'hAAAA, 1);
    add_item(bat_pkg::OP_ARRIVAL, 4'hC, 16'h5555, 1);
    add_item(bat_pkg::OP_TICK, 4'h5, 16'h1234, 1);
    // zero timeout behaves as one tick
    add_reg(bat_pkg::REG_TIMEOUT, 32'd0);
    add_item(bat_pkg::OP_ARRIVAL, 4'h1, 16'hFFFF, 1);
    add_typed(bat_pkg::OP_TICK, 4'hA, 16'hAAAA, 4'h1, 32'd65535, 16'd1,
              bat_pkg::CAUSE_TIMEOUT);
    // zero threshold releases on every arrival
    add_reg(bat_pkg::REG_THRESHOLD, 32'd0);
    add_typed(bat_pkg::OP_ARRIVAL, 4'h2, 16'h0000, 4'h2, 32'd0, 16'd1,
              bat_pkg::CAUSE_SIZE);
    add_item(bat_pkg::OP_ARRIVAL, 4'h0, 16'h00FF, 1);
    // longest timer and top threshold keep bursts open
    add_reg(bat_pkg::REG_TIMEOUT, 32'hFF_FFFF);
    add_reg(bat_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
    add_item(bat_pkg::OP_ARRIVAL, 4'h9, 16'd100, 1);
    add_item(bat_pkg::OP_ARRIVAL, 4'h9, 16'hFFFF, 3);
    add_item(bat_pkg::OP_ARRIVAL, 4'h4, 16'h1234, 1);
    add_item(bat_pkg::OP_TICK, 4'h6, 16'h8000, 1);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        write_register(stim_rows[i].idx, stim_rows[i].value);
      end else begin
        repeat (stim_rows[i].reps)
          send_item(stim_rows[i].op, stim_rows[i].dest, stim_rows[i].len,
                    stim_rows[i].typed, stim_rows[i].want);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      timeout_pick   = (phase == 1) ? 32'd1 : $urandom_range(2, 8);
      threshold_pick = (phase == 1) ? 32'd1 : $urandom_range(4000, 150000);
      write_register(bat_pkg::REG_TIMEOUT, timeout_pick);
      write_register(bat_pkg::REG_THRESHOLD, threshold_pick);
      send_idle_pct = send_idle_by_phase[phase];
      stall_pct     = stall_by_phase[phase];
      phase_items   = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if (phase == 0 && phase_items >= 20 && hold_requests == 0) hold_requests++;
        pick = $urandom_range(99);
        if (pick < 6) begin
          // open a burst on every destination, then sweep them
          for (int k = 0; k < bat_pkg::DESTINATIONS_DEF; k++)
            send_item(bat_pkg::OP_ARRIVAL, k[3:0], 16'($urandom_range(0, 3000)),
                      1'b0, '0);
          send_item(bat_pkg::OP_TICK, 4'($urandom_range(0, 15)),
                    16'($urandom_range(0, 65535)), 1'b0, '0);
          phase_items += bat_pkg::DESTINATIONS_DEF + 1;
        end else if (pick < 20) begin
          send_item(bat_pkg::OP_TICK, 4'($urandom_range(0, 15)),
                    16'($urandom_range(0, 65535)), 1'b0, '0);
          phase_items++;
        end else begin
          pick = $urandom_range(99);
          if (pick < 60) len_pick = 16'($urandom_range(0, 16000));
          else if (pick < 85) len_pick = 16'($urandom_range(0, 65535));
          else len_pick = pick[0] ? 16'hFFFF : 16'h0000;
          send_item(bat_pkg::OP_ARRIVAL, 4'($urandom_range(0, 15)), len_pick, 1'b0, '0);
          phase_items++;
        end
      end
    end

    settle();
    $display("run covered %0d input transfers (%0d ticks) and %0d release transfers",
             items_sent, ticks_sent, releases_seen);
    $display("directed extremes, then four idling phases with a long output hold");
    if (mismatch_count == 0 && pending_releases.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d releases outstanding", mismatch_count,
               pending_releases.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
